### src/wchm_pkg.sv
// shared constants, types and tables for the weighted circular heading mean
// no dependencies
package wchm_pkg;

    localparam int HistoryDepth = 8;
    localparam int SlotW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
    localparam int WeightW = $clog2(HistoryDepth + 1);
    localparam int CordicIters = 16;
    localparam int IterW = 4;
    localparam int HeadW = 16;
    localparam int TrigW = 19;
    localparam int SumW = TrigW + WeightW + SlotW + 2;
    localparam int VecW = SumW + 12;
    localparam int AngW = 25;

    localparam logic [HeadW-1:0] CdFull = 16'd36000;
    localparam logic [HeadW-1:0] CdQuarter = 16'd9000;
    localparam logic signed [AngW-1:0] CdHalfScaled = 25'sd4608000;
    localparam logic signed [AngW-1:0] CdFullScaled = 25'sd9216000;
    localparam logic signed [TrigW-1:0] CordicK = 19'sd39797;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH,
        ST_READ,
        ST_ROT,
        ST_ACC,
        ST_VEC,
        ST_DONE
    } state_t;

    function automatic logic signed [AngW-1:0] atan_entry(input logic [IterW-1:0] i);
        logic signed [AngW-1:0] v;
        unique case (i)
            4'd0: v = 25'sd1152000;
            4'd1: v = 25'sd680065;
            4'd2: v = 25'sd359328;
            4'd3: v = 25'sd182400;
            4'd4: v = 25'sd91554;
            4'd5: v = 25'sd45822;
            4'd6: v = 25'sd22916;
            4'd7: v = 25'sd11459;
            4'd8: v = 25'sd5730;
            4'd9: v = 25'sd2865;
            4'd10: v = 25'sd1432;
            4'd11: v = 25'sd716;
            4'd12: v = 25'sd358;
            4'd13: v = 25'sd179;
            4'd14: v = 25'sd90;
            default: v = 25'sd45;
        endcase
        return v;
    endfunction

endpackage

### src/weighted_circular_heading_mean.sv
// weighted circular heading mean top level: history ram, cordic datapath, sequencer
// depends on wchm_pkg and wchm_ram
//
//  channel | dir | handshake               | payload
//  s_      | in  | s_tvalid / s_tready     | tdata[15:0] heading, tuser fix_valid
//  m_      | out | m_tvalid / m_tready     | tdata[15:0] smooth heading
//
// one request at a time; a fix request walks the 8 entries oldest first, each by
// address, load, 16 cordic steps and accumulate, then runs 16 atan2 steps and the
// finish cycle, which loads the output register; a zero vector sum skips the atan2 steps
// a no-fix request goes from acceptance straight to the finish cycle
// s_tready returns the cycle after finish; after reset a clearing pass writes zero to
// every ram entry, s_tready low
// a stalled result holds in the output register; the finish cycle waits until it frees
module weighted_circular_heading_mean
    import wchm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // heading_centideg [15:0]
    input  logic        s_tuser,   // fix_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // smooth_heading_centideg [15:0]
);
    state_t state_reg, state_next;
    logic [SlotW-1:0] slot_reg, slot_next;
    logic [SlotW-1:0] cnt_reg, cnt_next;
    logic [IterW-1:0] it_reg, it_next;
    logic signed [VecW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [AngW-1:0] z_reg, z_next;
    logic [1:0] quad_reg, quad_next;
    logic signed [SumW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [15:0] out_reg, out_next;
    logic ovalid_reg, ovalid_next;

    logic ram_we;
    logic [SlotW-1:0] ram_addr;
    logic [HeadW-1:0] ram_wdata, ram_rdata;

    wchm_ram #(.Width(HeadW), .Depth(HistoryDepth)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata = out_reg;

    // angle reduction of the read entry
    logic [HeadW-1:0] a_mod, a_rem;
    logic [1:0] a_q;
    always_comb begin
        a_mod = (ram_rdata >= CdFull) ? ram_rdata - CdFull : ram_rdata;
        a_q = 2'd0;
        a_rem = a_mod;
        if (a_mod >= 3 * CdQuarter) begin
            a_q = 2'd3; a_rem = a_mod - 16'(3 * CdQuarter);
        end else if (a_mod >= 2 * CdQuarter) begin
            a_q = 2'd2; a_rem = a_mod - 16'(2 * CdQuarter);
        end else if (a_mod >= CdQuarter) begin
            a_q = 2'd1; a_rem = a_mod - CdQuarter;
        end
    end

    // shared cordic step
    logic signed [VecW-1:0] xs, ys;
    logic signed [AngW-1:0] at;
    logic rot_dir;
    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    assign at = atan_entry(it_reg);
    assign rot_dir = (state_reg == ST_ROT) ? (z_reg >= 0) : (y_reg <= 0);

    logic [SlotW-1:0] cnt_inc, oldest_idx;
    logic [WeightW-1:0] weight;
    logic signed [TrigW-1:0] cq, sq, xt, yt;
    logic signed [SumW-1:0] wc, ws;
    logic signed [AngW-1:0] zr;
    logic signed [AngW-1:0] zw;
    logic vec_zero;

    always_comb begin
        cnt_inc = (cnt_reg == SlotW'(HistoryDepth - 1)) ? '0 : cnt_reg + 1'b1;
        // ram index read for step cnt: oldest first, weight cnt+1
        oldest_idx = slot_reg;
        xt = x_reg[TrigW-1:0];
        yt = y_reg[TrigW-1:0];
        case (quad_reg)
            2'd0: begin cq = xt; sq = yt; end
            2'd1: begin cq = -yt; sq = xt; end
            2'd2: begin cq = -xt; sq = -yt; end
            default: begin cq = yt; sq = -xt; end
        endcase
        weight = WeightW'(cnt_reg) + 1'b1;
        wc = SumW'(cq) * $signed({1'b0, weight});
        ws = SumW'(sq) * $signed({1'b0, weight});
        zr = (z_reg + 25'sd128) >>> 8;
        zw = zr;
        if (zr < 0) zw = zr + 25'sd36000;
        else if (zr >= 25'sd36000) zw = zr - 25'sd36000;
        vec_zero = (sx_reg == 0) && (sy_reg == 0);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (cnt_reg == SlotW'(HistoryDepth - 1)) state_next = ST_IDLE;
            ST_IDLE: if (accept) state_next = s_tuser ? ST_FETCH : ST_DONE;
            ST_FETCH: state_next = ST_READ;
            ST_READ: state_next = ST_ROT;
            ST_ROT: if (it_reg == IterW'(CordicIters - 1)) state_next = ST_ACC;
            ST_ACC: state_next = (cnt_reg == SlotW'(HistoryDepth - 1)) ? ST_VEC : ST_FETCH;
            ST_VEC: if (vec_zero || it_reg == IterW'(CordicIters - 1)) state_next = ST_DONE;
            ST_DONE: if (!ovalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        slot_next = slot_reg;
        cnt_next = cnt_reg;
        it_next = it_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        quad_next = quad_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        out_next = out_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ram_we = 1'b0;
        ram_addr = cnt_reg + oldest_idx;
        ram_wdata = s_tdata;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                ram_addr = cnt_reg;
                ram_wdata = '0;
                cnt_next = cnt_inc;
            end
            ST_IDLE: begin
                ram_addr = slot_reg;
                cnt_next = '0;
                sx_next = '0;
                sy_next = '0;
                if (accept && s_tuser) begin
                    ram_we = 1'b1;
                    slot_next = (slot_reg == SlotW'(HistoryDepth - 1)) ? '0 : slot_reg + 1'b1;
                end
            end
            ST_FETCH: ;
            ST_READ: ;
            ST_ROT: begin
                x_next = rot_dir ? x_reg - ys : x_reg + ys;
                y_next = rot_dir ? y_reg + xs : y_reg - xs;
                z_next = rot_dir ? z_reg - at : z_reg + at;
                it_next = it_reg + 1'b1;
            end
            ST_ACC: begin
                sx_next = sx_reg + wc;
                sy_next = sy_reg + ws;
                cnt_next = cnt_inc;
                it_next = '0;
                if (cnt_reg == SlotW'(HistoryDepth - 1)) begin
                    x_next = VecW'(sx_reg + wc) <<< 8;
                    y_next = VecW'(sy_reg + ws) <<< 8;
                    z_next = '0;
                    if (sx_reg + wc < 0) begin
                        x_next = -(VecW'(sx_reg + wc) <<< 8);
                        y_next = -(VecW'(sy_reg + ws) <<< 8);
                        z_next = CdHalfScaled;
                    end
                    sx_next = sx_reg + wc;
                end
            end
            ST_VEC: begin
                if (!vec_zero) begin
                    x_next = rot_dir ? x_reg - ys : x_reg + ys;
                    y_next = rot_dir ? y_reg + xs : y_reg - xs;
                    z_next = rot_dir ? z_reg - at : z_reg + at;
                    it_next = it_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    out_next = vec_zero ? '0 : zw[15:0];
                end
            end
            default: ;
        endcase
        // entering rotation: load start vector from the registered read
        if (state_reg == ST_READ) begin
            x_next = VecW'(CordicK);
            y_next = '0;
            z_next = AngW'({a_rem, 8'd0});
            quad_next = a_q;
            it_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            slot_reg <= '0;
            cnt_reg <= '0;
            ovalid_reg <= 1'b0;
            it_reg <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg <= slot_next;
            cnt_reg <= cnt_next;
            ovalid_reg <= ovalid_next;
            it_reg <= it_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        quad_reg <= quad_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        out_reg <= out_next;
    end
endmodule

### src/wchm_ram.sv
// generic single port ram with registered read
// no dependencies
module wchm_ram #(
    parameter int Width = 16,
    parameter int Depth = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### tb/sv/weighted_circular_heading_mean_tb.sv
// testbench for weighted_circular_heading_mean: stream requests in, mean headings checked
// against an in-bench cordic predictor; depends on wchm_pkg and the block's rtl
`timescale 1ns / 1ps

module weighted_circular_heading_mean_tb;
    import wchm_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    weighted_circular_heading_mean i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial forever #2 aclk = ~aclk;

    localparam int WatchdogLimit = 20000;
    localparam int HoldCycles = 600;

    longint atan_lut [16] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
                              5730, 2865, 1432, 716, 358, 179, 90, 45};

    logic [15:0] history [HistoryDepth];
    int          next_slot;
    logic [15:0] mean_queue [$];
    int          mismatches = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    logic        hold_active = 1'b0;
    event        hold_trigger;
    int          quiet_cycles = 0;

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic void heading_trig(input int a, output longint c, output longint s);
        longint x, y, z, nx, ny;
        int q, r;
        a = a % 36000;
        q = a / 9000;
        r = a % 9000;
        x = 39797;
        y = 0;
        z = longint'(r) * 256;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z -= atan_lut[i];
            end else begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z += atan_lut[i];
            end
            x = nx;
            y = ny;
        end
        case (q)
            0: begin c = x; s = y; end
            1: begin c = -y; s = x; end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic [15:0] vector_heading(longint yv, longint xv);
        longint z, nx, ny, r;
        z = 0;
        if (xv == 0 && yv == 0) return 16'd0;
        xv *= 256;
        yv *= 256;
        if (xv < 0) begin
            xv = -xv;
            yv = -yv;
            z = 18000 * 256;
        end
        for (int i = 0; i < 16; i++) begin
            if (yv > 0) begin
                nx = xv + floor_shift(yv, i);
                ny = yv - floor_shift(xv, i);
                z += atan_lut[i];
            end else begin
                nx = xv - floor_shift(yv, i);
                ny = yv + floor_shift(xv, i);
                z -= atan_lut[i];
            end
            xv = nx;
            yv = ny;
        end
        r = floor_shift(z + 128, 8);
        while (r < 0) r += 36000;
        while (r >= 36000) r -= 36000;
        return 16'(r);
    endfunction

    function automatic logic [15:0] predict_mean(logic [15:0] heading, logic fix);
        longint sx, sy, c, s;
        int idx;
        sx = 0;
        sy = 0;
        if (!fix) return 16'd0;
        history[next_slot] = heading;
        next_slot = (next_slot + 1) % HistoryDepth;
        for (int i = 0; i < HistoryDepth; i++) begin
            idx = (next_slot + 2 * HistoryDepth - 1 - i) % HistoryDepth;
            heading_trig(history[idx], c, s);
            sx += c * (HistoryDepth - i);
            sy += s * (HistoryDepth - i);
        end
        return vector_heading(sy, sx);
    endfunction

    task automatic send_request(logic [15:0] heading, logic fix);
        logic ready_seen;
        ready_seen = 1'b0;
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= heading;
        s_tuser  <= fix;
        mean_queue.push_back(predict_mean(heading, fix));
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
    endtask

    // long receiver hold-off, counted here
    always begin
        @(hold_trigger);
        hold_active <= 1'b1;
        repeat (HoldCycles) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // receiver side
    always @(posedge aclk) begin
        if (hold_active) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (mean_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", m_tdata);
            end else if (mean_queue[0] !== m_tdata) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d actual %0d", mean_queue[0], m_tdata);
                void'(mean_queue.pop_front());
            end else begin
                void'(mean_queue.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("weighted_circular_heading_mean_tb: errors");
            $finish;
        end
    end

    function automatic logic [15:0] random_heading();
        case ($urandom_range(9))
            0: return 16'($urandom_range(65535));
            1: return 16'(9000 * $urandom_range(3));
            default: return 16'($urandom_range(35999));
        endcase
    endfunction

    task automatic test_extremes();
        logic [15:0] edges [10] = '{0, 35999, 9000, 8999, 18000, 27000, 36000, 65535, 17999,
                                    100};
        foreach (edges[i]) send_request(edges[i], 1'b1);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd1234, 1'b0);
    endtask

    task automatic test_opposing_cancel();
        // equal opposite headings drive the sum toward zero
        for (int i = 0; i < 8; i++) send_request((i % 2) ? 16'd18000 : 16'd0, 1'b1);
        for (int i = 0; i < 4; i++) send_request(16'd27000, 1'b1);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 15) send_request(16'($urandom_range(65535)), 1'b0);
            else send_request(random_heading(), 1'b1);
        end
    endtask

    task automatic test_backpressure();
        -> hold_trigger;
        test_random(20);
    endtask

    initial begin
        next_slot = 0;
        foreach (history[i]) history[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_opposing_cancel();
        send_idle = 16;
        recv_idle = 85;
        test_random(350);
        send_idle = 85;
        recv_idle = 16;
        test_random(350);
        send_idle = 0;
        recv_idle = 0;
        test_backpressure();
        test_random(350);
        s_tvalid <= 1'b0;
        while (mean_queue.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("weighted_circular_heading_mean_tb: clean");
        end else begin
            $display("weighted_circular_heading_mean_tb: errors");
        end
        $finish;
    end
endmodule
